// ===== src/oas_pkg.sv =====
`default_nettype none

package oas_pkg;

  // default capacity in words
  localparam int unsigned DEPTH   = 256;
  localparam int unsigned COUNT_W = $clog2(DEPTH + 1);
  localparam int unsigned WORD_W  = 32;

  // request action codes
  typedef enum logic [2:0] {
    ACT_PUSH      = 3'd0,
    ACT_INSERT    = 3'd1,
    ACT_POP       = 3'd2,
    ACT_REMOVE_AT = 3'd3,
    ACT_REMOVE_EQ = 3'd4,
    ACT_READ      = 3'd5
  } action_e;

  // response status codes
  typedef enum logic [1:0] {
    STS_OK    = 2'd0,
    STS_RANGE = 2'd1,
    STS_EMPTY = 2'd2,
    STS_FULL  = 2'd3
  } status_e;

  // controller states
  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCAN  = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_FIN   = 4'b1000
  } state_e;

endpackage

`default_nettype wire

// ===== src/oas_if.sv =====
`default_nettype none

// request channel
interface oas_req_if;
  logic                valid;
  logic                ready;
  logic [2:0]          action;
  logic [7:0]          index;
  logic signed [31:0]  operand_value;

  modport source (output valid, action, index, operand_value, input ready);
  modport sink   (input valid, action, index, operand_value, output ready);
endinterface

// response channel
interface oas_rsp_if #(
  parameter int unsigned CountWidth = oas_pkg::COUNT_W
);
  logic                  valid;
  logic                  ready;
  logic signed [31:0]    result_value;
  logic [CountWidth-1:0] item_count;
  logic [1:0]            status;
  logic [CountWidth-1:0] removed_count;

  modport source (output valid, result_value, item_count, status, removed_count,
                  input ready);
  modport sink   (input valid, result_value, item_count, status, removed_count,
                  output ready);
endinterface

`default_nettype wire

// ===== src/oas_mem.sv =====
`default_nettype none

// word memory: one write port, one read port with registered read data
module oas_mem #(
  parameter int unsigned Depth = oas_pkg::DEPTH,
  localparam int unsigned AW   = $clog2(Depth)
) (
  input  wire logic                        clk_i,
  input  wire logic                        we_i,
  input  wire logic [AW-1:0]               waddr_i,
  input  wire logic [oas_pkg::WORD_W-1:0]  wdata_i,
  input  wire logic                        re_i,
  input  wire logic [AW-1:0]               raddr_i,
  output      logic [oas_pkg::WORD_W-1:0]  rdata_o
);

  logic [oas_pkg::WORD_W-1:0] mem_q [Depth];
  logic [oas_pkg::WORD_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== src/oas_ctrl.sv =====
`default_nettype none

// request decode, scan sequencer and response register
module oas_ctrl #(
  parameter int unsigned Depth = oas_pkg::DEPTH,
  localparam int unsigned AW   = $clog2(Depth),
  localparam int unsigned CW   = $clog2(Depth + 1),
  localparam int unsigned XW   = (CW > 8) ? CW : 8
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  oas_req_if.sink                          req_i,
  oas_rsp_if.source                        rsp_o,
  output      logic                        mem_we_o,
  output      logic [AW-1:0]               mem_waddr_o,
  output      logic [oas_pkg::WORD_W-1:0]  mem_wdata_o,
  output      logic                        mem_re_o,
  output      logic [AW-1:0]               mem_raddr_o,
  input  wire logic [oas_pkg::WORD_W-1:0]  mem_rdata_i
);

  oas_pkg::state_e  state_q, state_d;
  oas_pkg::action_e op_q, op_d;
  logic [AW-1:0]    idx_q, idx_d;
  logic [31:0]      val_q, val_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic [AW-1:0]    ptr_q, ptr_d;
  logic [AW-1:0]    last_q, last_d;
  logic             up_q, up_d;
  logic             rv_q, rv_d;
  logic [AW-1:0]    rv_addr_q, rv_addr_d;
  logic [31:0]      res_q, res_d;
  logic [CW-1:0]    keep_q, keep_d;
  logic [CW-1:0]    removed_q, removed_d;

  logic             out_valid_q, out_valid_d;
  logic [31:0]      out_res_q, out_res_d;
  logic [CW-1:0]    out_cnt_q, out_cnt_d;
  logic [1:0]       out_status_q, out_status_d;
  logic [CW-1:0]    out_removed_q, out_removed_d;

  logic             accept;
  logic             out_load;
  logic [XW-1:0]    idx_ext, cnt_ext;
  logic             in_range, is_full, is_empty;
  logic [AW-1:0]    cnt_last;

  assign req_i.ready = (state_q == oas_pkg::ST_IDLE) && (!out_valid_q || rsp_o.ready);
  assign accept      = req_i.valid && req_i.ready;

  assign idx_ext  = XW'(req_i.index);
  assign cnt_ext  = XW'(cnt_q);
  assign in_range = idx_ext < cnt_ext;
  assign is_full  = cnt_q == CW'(Depth);
  assign is_empty = cnt_q == '0;
  assign cnt_last = AW'(cnt_q - CW'(1));

  always_comb begin
    state_d   = state_q;
    op_d      = op_q;
    idx_d     = idx_q;
    val_d     = val_q;
    cnt_d     = cnt_q;
    ptr_d     = ptr_q;
    last_d    = last_q;
    up_d      = up_q;
    rv_d      = 1'b0;
    rv_addr_d = rv_addr_q;
    res_d     = res_q;
    keep_d    = keep_q;
    removed_d = removed_q;

    out_load      = 1'b0;
    out_res_d     = out_res_q;
    out_cnt_d     = out_cnt_q;
    out_status_d  = out_status_q;
    out_removed_d = out_removed_q;

    mem_we_o    = 1'b0;
    mem_waddr_o = '0;
    mem_wdata_o = '0;
    mem_re_o    = 1'b0;
    mem_raddr_o = ptr_q;

    // process the word read in the previous cycle
    if (rv_q) begin
      case (op_q)
        oas_pkg::ACT_INSERT: begin
          mem_we_o    = 1'b1;
          mem_waddr_o = rv_addr_q + AW'(1);
          mem_wdata_o = mem_rdata_i;
        end
        oas_pkg::ACT_REMOVE_AT: begin
          if (rv_addr_q == idx_q) begin
            res_d = mem_rdata_i;
          end else begin
            mem_we_o    = 1'b1;
            mem_waddr_o = rv_addr_q - AW'(1);
            mem_wdata_o = mem_rdata_i;
          end
        end
        oas_pkg::ACT_REMOVE_EQ: begin
          if (mem_rdata_i == val_q) begin
            removed_d = removed_q + CW'(1);
          end else begin
            mem_we_o    = 1'b1;
            mem_waddr_o = AW'(keep_q);
            mem_wdata_o = mem_rdata_i;
            keep_d      = keep_q + CW'(1);
          end
        end
        default: begin
          res_d = mem_rdata_i;
        end
      endcase
    end

    case (state_q)
      // decode; short actions and errors answer at once
      oas_pkg::ST_IDLE: begin
        if (accept) begin
          op_d         = oas_pkg::action_e'(req_i.action);
          idx_d        = AW'(req_i.index);
          val_d        = $unsigned(req_i.operand_value);
          res_d        = '0;
          keep_d       = '0;
          removed_d    = '0;
          out_res_d    = '0;
          out_cnt_d    = cnt_q;
          out_status_d = oas_pkg::STS_OK;
          out_removed_d = '0;
          case (req_i.action)
            oas_pkg::ACT_PUSH: begin
              out_load = 1'b1;
              if (is_full) begin
                out_status_d = oas_pkg::STS_FULL;
              end else begin
                mem_we_o    = 1'b1;
                mem_waddr_o = AW'(cnt_q);
                mem_wdata_o = $unsigned(req_i.operand_value);
                cnt_d       = cnt_q + CW'(1);
                out_cnt_d   = cnt_q + CW'(1);
              end
            end
            oas_pkg::ACT_INSERT: begin
              if (!in_range) begin
                out_load     = 1'b1;
                out_status_d = oas_pkg::STS_RANGE;
              end else if (is_full) begin
                out_load     = 1'b1;
                out_status_d = oas_pkg::STS_FULL;
              end else begin
                ptr_d   = cnt_last;
                last_d  = AW'(req_i.index);
                up_d    = 1'b0;
                state_d = oas_pkg::ST_SCAN;
              end
            end
            oas_pkg::ACT_POP: begin
              if (is_empty) begin
                out_load     = 1'b1;
                out_status_d = oas_pkg::STS_EMPTY;
              end else begin
                ptr_d   = cnt_last;
                last_d  = cnt_last;
                up_d    = 1'b1;
                state_d = oas_pkg::ST_SCAN;
              end
            end
            oas_pkg::ACT_REMOVE_AT: begin
              if (!in_range) begin
                out_load     = 1'b1;
                out_status_d = oas_pkg::STS_RANGE;
              end else begin
                ptr_d   = AW'(req_i.index);
                last_d  = cnt_last;
                up_d    = 1'b1;
                state_d = oas_pkg::ST_SCAN;
              end
            end
            oas_pkg::ACT_REMOVE_EQ: begin
              if (is_empty) begin
                out_load = 1'b1;
              end else begin
                ptr_d   = '0;
                last_d  = cnt_last;
                up_d    = 1'b1;
                state_d = oas_pkg::ST_SCAN;
              end
            end
            oas_pkg::ACT_READ: begin
              if (!in_range) begin
                out_load     = 1'b1;
                out_status_d = oas_pkg::STS_RANGE;
              end else begin
                ptr_d   = AW'(req_i.index);
                last_d  = AW'(req_i.index);
                up_d    = 1'b1;
                state_d = oas_pkg::ST_SCAN;
              end
            end
            default: begin
              out_load = 1'b1;
            end
          endcase
        end
      end

      // one read per cycle across the range
      oas_pkg::ST_SCAN: begin
        mem_re_o  = 1'b1;
        rv_d      = 1'b1;
        rv_addr_d = ptr_q;
        if (ptr_q == last_q) begin
          state_d = oas_pkg::ST_DRAIN;
        end else if (up_q) begin
          ptr_d = ptr_q + AW'(1);
        end else begin
          ptr_d = ptr_q - AW'(1);
        end
      end

      // last read word is handled above
      oas_pkg::ST_DRAIN: begin
        state_d = oas_pkg::ST_FIN;
      end

      // commit count, place inserted word, load response
      oas_pkg::ST_FIN: begin
        out_load      = 1'b1;
        out_status_d  = oas_pkg::STS_OK;
        out_res_d     = res_q;
        out_removed_d = removed_q;
        case (op_q)
          oas_pkg::ACT_INSERT: begin
            mem_we_o    = 1'b1;
            mem_waddr_o = idx_q;
            mem_wdata_o = val_q;
            cnt_d       = cnt_q + CW'(1);
          end
          oas_pkg::ACT_POP,
          oas_pkg::ACT_REMOVE_AT: begin
            cnt_d = cnt_q - CW'(1);
          end
          oas_pkg::ACT_REMOVE_EQ: begin
            cnt_d = keep_q;
          end
          default: begin
            cnt_d = cnt_q;
          end
        endcase
        out_cnt_d = cnt_d;
        state_d   = oas_pkg::ST_IDLE;
      end

      default: begin
        state_d = oas_pkg::ST_IDLE;
      end
    endcase

    // response register
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= oas_pkg::ST_IDLE;
      cnt_q       <= '0;
      rv_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      rv_q        <= rv_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    op_q          <= op_d;
    idx_q         <= idx_d;
    val_q         <= val_d;
    ptr_q         <= ptr_d;
    last_q        <= last_d;
    up_q          <= up_d;
    rv_addr_q     <= rv_addr_d;
    res_q         <= res_d;
    keep_q        <= keep_d;
    removed_q     <= removed_d;
    out_res_q     <= out_res_d;
    out_cnt_q     <= out_cnt_d;
    out_status_q  <= out_status_d;
    out_removed_q <= out_removed_d;
  end

  assign rsp_o.valid         = out_valid_q;
  assign rsp_o.result_value  = $signed(out_res_q);
  assign rsp_o.item_count    = out_cnt_q;
  assign rsp_o.status        = out_status_q;
  assign rsp_o.removed_count = out_removed_q;

endmodule

`default_nettype wire

// ===== src/ordered_array_store_top.sv =====
`default_nettype none

// Bounded ordered array of signed 32-bit words held in a single-port-write,
// single-port-read memory of Depth words. One request is taken at a time and
// answered with one response. Push, remove-all-equal on an empty store, an
// unknown action, and every request rejected with a status (range, empty,
// full) answer in the cycle after acceptance. Read and pop take one memory
// read and go through the scan, drain and finish states. Insert and
// remove-at-index move the words between the index and the end one per cycle.
// Remove-all-equal on a non-empty store scans every stored word once. The pace
// is set by the memory's one read and one write per cycle. Words beyond the
// count are never read, so the memory needs no clearing after reset and
// requests are taken from the first cycle.
module ordered_array_store_top #(
  parameter int unsigned Depth = oas_pkg::DEPTH
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  oas_req_if.sink    req_i,
  oas_rsp_if.source  rsp_o
);

  localparam int unsigned AW = $clog2(Depth);

  logic                       mem_we;
  logic [AW-1:0]              mem_waddr;
  logic [oas_pkg::WORD_W-1:0] mem_wdata;
  logic                       mem_re;
  logic [AW-1:0]              mem_raddr;
  logic [oas_pkg::WORD_W-1:0] mem_rdata;

  oas_ctrl #(
    .Depth (Depth)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .rsp_o       (rsp_o),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  oas_mem #(
    .Depth (Depth)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

endmodule

`default_nettype wire
